// ===== rtl/core/rnls_pkg.sv =====
// Shared types, constants and the digit decoding function for the radix number literal scanner.
// No dependencies.
package rnls_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ZERO = 2'd1,
    PH_INT  = 2'd2,
    PH_FRAC = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    RX_BIN = 2'd0,
    RX_OCT = 2'd1,
    RX_DEC = 2'd2,
    RX_HEX = 2'd3
  } radix_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  localparam int FRAC_GUARD = 8;
  // depth of the decimal fraction weight table
  localparam int DEC_DEPTH  = 32;

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF   = 8'h66;
  localparam logic [7:0] CH_UB   = 8'h42;
  localparam logic [7:0] CH_LB   = 8'h62;
  localparam logic [7:0] CH_UO   = 8'h4F;
  localparam logic [7:0] CH_LO   = 8'h6F;
  localparam logic [7:0] CH_UX   = 8'h58;
  localparam logic [7:0] CH_LX   = 8'h78;

  // digit value of c, valid only when it is below the radix
  function automatic digit_t digit_of(logic [7:0] c, radix_t rx);
    digit_t     r;
    logic [7:0] v;
    logic       hit;
    v   = 8'd0;
    hit = 1'b0;
    if (c >= CH_0 && c <= CH_9) begin
      v   = c - CH_0;
      hit = 1'b1;
    end else if (c >= CH_LA && c <= CH_LF) begin
      v   = c - CH_LA + 8'd10;
      hit = 1'b1;
    end else if (c >= CH_UA && c <= CH_UF) begin
      v   = c - CH_UA + 8'd10;
      hit = 1'b1;
    end
    case (rx)
      RX_BIN:  r.ok = hit && (v < 8'd2);
      RX_OCT:  r.ok = hit && (v < 8'd8);
      RX_DEC:  r.ok = hit && (v < 8'd10);
      RX_HEX:  r.ok = hit;
      default: r.ok = 1'b0;
    endcase
    r.val = v[3:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/radix_number_literal_scanner.sv =====
// Number literal scanner: one character per cycle while in_stall is low, binary/octal/decimal/hex
// integers with optional fraction. Depends on rnls_pkg.
// The ending character of a literal is loaded into the input register; its result is then
// loaded into the result register, which drives out_, once that register is free.
// Throughput: one character per cycle; in_stall rises only while the input register
// and the result register are both full and out_stall is high. Reset (rst_n,
// synchronous) empties both registers and returns the scanner to idle, decimal, zero.
module radix_number_literal_scanner
  import rnls_pkg::*;
#(
  parameter int FRAC_BITS = 32,
  parameter int INT_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_starts_literal,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_int_value,
  output logic [31:0]        out_frac_value,
  output logic               out_is_real,
  output logic [1:0]         out_radix_code,
  output logic               out_char_taken
);

  localparam int WORK_BITS = FRAC_BITS + FRAC_GUARD;
  localparam int WGT_W     = WORK_BITS + 1;
  localparam int KMAX      = WORK_BITS + 1;
  localparam int K_W       = $clog2(KMAX + 1);
  localparam int SH_W      = $clog2(4 * KMAX + 1);
  localparam int PROD_W    = WGT_W + 4;
  localparam int DEC_IW    = $clog2(DEC_DEPTH);
  localparam logic [WGT_W-1:0] WGT_ONE = {1'b1, {WORK_BITS{1'b0}}};

  // input register
  logic       in_v_r;
  logic [7:0] ch_r;
  logic       st_r;

  // scanner state
  phase_t                 phase_r, phase_nxt;
  radix_t                 radix_r, radix_nxt;
  logic [INT_BITS-1:0]    int_acc_r, int_acc_nxt;
  logic [WORK_BITS-1:0]   frac_acc_r, frac_acc_nxt;
  logic [K_W-1:0]         fdig_r, fdig_nxt;
  logic                   real_r, real_nxt;

  // result register
  logic                   out_v_r;
  logic [31:0]            int_o_r, int_o_nxt;
  logic [31:0]            frac_o_r, frac_o_nxt;
  logic                   real_o_r, real_o_nxt;
  logic [1:0]             rx_o_r, rx_o_nxt;
  logic                   taken_o_r, taken_o_nxt;

  logic                   fire;
  logic                   emit;
  digit_t                 dg;
  logic [INT_BITS-1:0]    int_step;
  logic [K_W-1:0]         fdig_inc;
  logic [SH_W-1:0]        fdig_ext;
  logic [SH_W-1:0]        shamt;
  logic [WGT_W-1:0]       weight;
  logic [PROD_W-1:0]      prod;
  logic [WGT_W-1:0]       dec_tab [DEC_DEPTH];
  logic [INT_BITS+31:0]   int_ext;
  logic [WORK_BITS+31:0]  frac_ext;

  // decimal weights floor(2^WORK_BITS / 10^k), worked out at elaboration
  for (genvar g = 0; g < DEC_DEPTH; g++) begin : g_dec
    localparam logic [127:0] NUM = 128'd1 << WORK_BITS;
    localparam logic [127:0] DEN = 128'd10 ** g;
    assign dec_tab[g] = WGT_W'(NUM / DEN);
  end

  assign fire     = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && out_v_r && out_stall;

  assign dg = digit_of(ch_r, radix_r);

  // int_acc * radix + digit, wrapping
  always_comb begin
    case (radix_r)
      RX_BIN:  int_step = int_acc_r << 1;
      RX_OCT:  int_step = int_acc_r << 3;
      RX_DEC:  int_step = (int_acc_r << 3) + (int_acc_r << 1);
      RX_HEX:  int_step = int_acc_r << 4;
      default: int_step = int_acc_r;
    endcase
    int_step = int_step + INT_BITS'(dg.val);
  end

  // weight of the next fraction digit; saturate once it has reached zero
  assign fdig_inc = (fdig_r == K_W'(KMAX)) ? fdig_r : fdig_r + K_W'(1);
  assign fdig_ext = SH_W'(fdig_inc);

  always_comb begin
    case (radix_r)
      RX_BIN:  shamt = fdig_ext;
      RX_OCT:  shamt = fdig_ext + (fdig_ext << 1);
      RX_HEX:  shamt = fdig_ext << 2;
      default: shamt = fdig_ext;
    endcase
    if (radix_r == RX_DEC) begin
      if (fdig_inc < K_W'(DEC_DEPTH)) begin
        weight = dec_tab[fdig_inc[DEC_IW-1:0]];
      end else begin
        weight = '0;
      end
    end else begin
      weight = WGT_ONE >> shamt;
    end
    prod = PROD_W'(weight) * PROD_W'(dg.val);
  end

  assign int_ext  = {{32{int_acc_r[INT_BITS-1]}}, int_acc_r};
  assign frac_ext = {32'd0, frac_acc_r};

  // next state and result for the beat in the input register
  always_comb begin
    phase_nxt    = phase_r;
    radix_nxt    = radix_r;
    int_acc_nxt  = int_acc_r;
    frac_acc_nxt = frac_acc_r;
    fdig_nxt     = fdig_r;
    real_nxt     = real_r;
    emit         = 1'b0;
    int_o_nxt    = 32'd0;
    frac_o_nxt   = 32'd0;
    real_o_nxt   = 1'b0;
    rx_o_nxt     = RX_DEC;
    taken_o_nxt  = 1'b0;

    if (st_r) begin
      // drop any literal in progress and start over
      radix_nxt    = RX_DEC;
      int_acc_nxt  = '0;
      frac_acc_nxt = '0;
      fdig_nxt     = '0;
      real_nxt     = 1'b0;
      if (ch_r == CH_0) begin
        phase_nxt = PH_ZERO;
      end else if (ch_r >= CH_1 && ch_r <= CH_9) begin
        phase_nxt   = PH_INT;
        int_acc_nxt = INT_BITS'(ch_r - CH_0);
      end else begin
        phase_nxt = PH_IDLE;
      end
    end else begin
      case (phase_r)
        PH_ZERO: begin
          int_acc_nxt  = '0;
          frac_acc_nxt = '0;
          fdig_nxt     = '0;
          real_nxt     = 1'b0;
          radix_nxt    = RX_DEC;
          phase_nxt    = PH_INT;
          if (ch_r == CH_LB || ch_r == CH_UB) begin
            radix_nxt = RX_BIN;
          end else if (ch_r == CH_LO || ch_r == CH_UO) begin
            radix_nxt = RX_OCT;
          end else if (ch_r == CH_LX || ch_r == CH_UX) begin
            radix_nxt = RX_HEX;
          end else if (ch_r == CH_DOT) begin
            phase_nxt = PH_FRAC;
            real_nxt  = 1'b1;
          end else begin
            // lone zero: swallow the character and give 0
            phase_nxt   = PH_IDLE;
            emit        = 1'b1;
            taken_o_nxt = 1'b1;
          end
        end
        PH_INT: begin
          if (dg.ok) begin
            int_acc_nxt = int_step;
          end else if (ch_r == CH_DOT) begin
            phase_nxt = PH_FRAC;
            real_nxt  = 1'b1;
          end else begin
            emit         = 1'b1;
            int_o_nxt    = int_ext[31:0];
            rx_o_nxt     = radix_r;
            phase_nxt    = PH_IDLE;
            radix_nxt    = RX_DEC;
            int_acc_nxt  = '0;
            frac_acc_nxt = '0;
            fdig_nxt     = '0;
            real_nxt     = 1'b0;
          end
        end
        PH_FRAC: begin
          if (dg.ok) begin
            fdig_nxt     = fdig_inc;
            frac_acc_nxt = frac_acc_r + prod[WORK_BITS-1:0];
          end else begin
            emit         = 1'b1;
            int_o_nxt    = int_ext[31:0];
            frac_o_nxt   = frac_ext[FRAC_GUARD +: 32];
            real_o_nxt   = real_r;
            rx_o_nxt     = radix_r;
            phase_nxt    = PH_IDLE;
            radix_nxt    = RX_DEC;
            int_acc_nxt  = '0;
            frac_acc_nxt = '0;
            fdig_nxt     = '0;
            real_nxt     = 1'b0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      phase_r    <= PH_IDLE;
      radix_r    <= RX_DEC;
      int_acc_r  <= '0;
      frac_acc_r <= '0;
      fdig_r     <= '0;
      real_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_v_r <= 1'b1;
      end else if (fire) begin
        in_v_r <= 1'b0;
      end
      if (fire) begin
        phase_r    <= phase_nxt;
        radix_r    <= radix_nxt;
        int_acc_r  <= int_acc_nxt;
        frac_acc_r <= frac_acc_nxt;
        fdig_r     <= fdig_nxt;
        real_r     <= real_nxt;
      end
      if (fire && emit) begin
        out_v_r <= 1'b1;
      end else if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ch_r <= in_char_code;
      st_r <= in_starts_literal;
    end
    if (fire && emit) begin
      int_o_r   <= int_o_nxt;
      frac_o_r  <= frac_o_nxt;
      real_o_r  <= real_o_nxt;
      rx_o_r    <= rx_o_nxt;
      taken_o_r <= taken_o_nxt;
    end
  end

  assign out_valid      = out_v_r;
  assign out_int_value  = int_o_r;
  assign out_frac_value = frac_o_r;
  assign out_is_real    = real_o_r;
  assign out_radix_code = rx_o_r;
  assign out_char_taken = taken_o_r;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for radix_number_literal_scanner: drives character beats,
// predicts each scanned literal and compares it with the out_ channel.
// Depends on rnls_pkg and the scanner RTL.
module tb;
  import rnls_pkg::*;

  localparam int WORK_BITS = 32 + FRAC_GUARD;
  localparam int LIMIT     = 200000;

  typedef struct packed {
    logic [7:0] code;
    logic       start;
  } char_beat_t;

  typedef struct {
    logic [31:0] int_val;
    logic [31:0] frac_val;
    logic        real_flag;
    radix_t      radix;
    logic        taken;
  } literal_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_char_code = 8'h00;
  logic               in_starts_literal = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_int_value;
  logic [31:0]        out_frac_value;
  logic               out_is_real;
  logic [1:0]         out_radix_code;
  logic               out_char_taken;

  char_beat_t text_chars[$];
  literal_t   want_literals[$];
  int         pushed_chars = 0;
  int         errors = 0;
  int         cycles = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       hold_req = 1'b0;
  logic       hold_used;
  int         hold_left;

  // scanner image
  phase_t      scan_ph = PH_IDLE;
  radix_t      scan_rx = RX_DEC;
  logic [31:0] acc_int = '0;
  logic [63:0] acc_frac = '0;
  logic [63:0] frac_wt = 64'd1 << WORK_BITS;
  logic        real_seen = 1'b0;

  radix_number_literal_scanner u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_starts_literal(in_starts_literal),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_int_value    (out_int_value),
    .out_frac_value   (out_frac_value),
    .out_is_real      (out_is_real),
    .out_radix_code   (out_radix_code),
    .out_char_taken   (out_char_taken)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int base_of(radix_t rx);
    case (rx)
      RX_BIN:  return 2;
      RX_OCT:  return 8;
      RX_DEC:  return 10;
      default: return 16;
    endcase
  endfunction

  // value of c as a digit of rx, -1 when it is not one
  function automatic int digit_value(logic [7:0] c, radix_t rx);
    int v;
    v = -1;
    if (c >= CH_0 && c <= CH_9) v = int'(c - CH_0);
    else if (c >= CH_LA && c <= CH_LF) v = int'(c - CH_LA) + 10;
    else if (c >= CH_UA && c <= CH_UF) v = int'(c - CH_UA) + 10;
    if (v >= base_of(rx)) v = -1;
    return v;
  endfunction

  task automatic open_literal(phase_t ph, radix_t rx);
    scan_ph   = ph;
    scan_rx   = rx;
    acc_int   = '0;
    acc_frac  = '0;
    frac_wt   = 64'd1 << WORK_BITS;
    real_seen = 1'b0;
  endtask

  task automatic add_result(logic [31:0] iv, logic [31:0] fv, logic rf, radix_t rx,
                            logic tk);
    literal_t lit;
    lit.int_val   = iv;
    lit.frac_val  = fv;
    lit.real_flag = rf;
    lit.radix     = rx;
    lit.taken     = tk;
    want_literals.push_back(lit);
  endtask

  // advance the scanner image by one accepted character
  task automatic scan_char(logic [7:0] c, logic s);
    int d;
    if (s) begin
      if (c == CH_0) open_literal(PH_ZERO, RX_DEC);
      else if (c >= CH_1 && c <= CH_9) begin
        open_literal(PH_INT, RX_DEC);
        acc_int = 32'(c - CH_0);
      end else open_literal(PH_IDLE, RX_DEC);
    end else begin
      case (scan_ph)
        PH_ZERO: begin
          if (c == CH_LB || c == CH_UB) open_literal(PH_INT, RX_BIN);
          else if (c == CH_LO || c == CH_UO) open_literal(PH_INT, RX_OCT);
          else if (c == CH_LX || c == CH_UX) open_literal(PH_INT, RX_HEX);
          else if (c == CH_DOT) begin
            open_literal(PH_FRAC, RX_DEC);
            real_seen = 1'b1;
          end else begin
            add_result('0, '0, 1'b0, RX_DEC, 1'b1);
            open_literal(PH_IDLE, RX_DEC);
          end
        end
        PH_INT: begin
          d = digit_value(c, scan_rx);
          if (d >= 0) acc_int = acc_int * 32'(base_of(scan_rx)) + 32'(d);
          else if (c == CH_DOT) begin
            scan_ph   = PH_FRAC;
            real_seen = 1'b1;
          end else begin
            add_result(acc_int, '0, 1'b0, scan_rx, 1'b0);
            open_literal(PH_IDLE, RX_DEC);
          end
        end
        PH_FRAC: begin
          d = digit_value(c, scan_rx);
          if (d >= 0) begin
            frac_wt  = frac_wt / 64'(base_of(scan_rx));
            acc_frac = acc_frac + frac_wt * 64'(d);
          end else begin
            add_result(acc_int, acc_frac[FRAC_GUARD +: 32], 1'b1, scan_rx, 1'b0);
            open_literal(PH_IDLE, RX_DEC);
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, expected %h (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  task automatic check_result();
    literal_t lit;
    if (want_literals.size() == 0) begin
      flag_mismatch("unexpected beat int", out_int_value, '0);
    end else begin
      lit = want_literals.pop_front();
      if (out_int_value !== lit.int_val) flag_mismatch("int", out_int_value, lit.int_val);
      if (out_frac_value !== lit.frac_val)
        flag_mismatch("frac", out_frac_value, lit.frac_val);
      if (out_is_real !== lit.real_flag) flag_mismatch("is_real", out_is_real, lit.real_flag);
      if (out_radix_code !== lit.radix) flag_mismatch("radix", out_radix_code, lit.radix);
      if (out_char_taken !== lit.taken) flag_mismatch("taken", out_char_taken, lit.taken);
    end
  endtask

  // driver: advance on acceptance, hold while stalled
  always @(posedge clk) begin : drive_proc
    char_beat_t beat;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) scan_char(in_char_code, in_starts_literal);
      if (!in_valid || !in_stall) begin
        if (text_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          beat = text_chars.pop_front();
          in_valid          <= 1'b1;
          in_char_code      <= beat.code;
          in_starts_literal <= beat.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // one long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_req && !hold_used) begin
      hold_left <= 400;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL radix_number_literal_scanner");
      $finish;
    end
  end

  task automatic add_char(logic [7:0] c, logic s);
    char_beat_t beat;
    beat.code  = c;
    beat.start = s;
    text_chars.push_back(beat);
    pushed_chars++;
  endtask

  function automatic logic [7:0] digit_char(radix_t rx);
    int v;
    v = $urandom_range(base_of(rx) - 1);
    if (v < 10) return 8'(CH_0 + v);
    return 8'(($urandom_range(1) ? CH_LA : CH_UA) + v - 10);
  endfunction

  function automatic logic [7:0] end_char(radix_t rx, bit in_int);
    logic [7:0] c;
    for (int i = 0; i < 64; i++) begin
      case ($urandom_range(3))
        0:       c = " ";
        1:       c = ";";
        2:       c = CH_DOT;
        default: c = 8'($urandom_range(255));
      endcase
      if (digit_value(c, rx) < 0 && !(in_int && c == CH_DOT)) return c;
    end
    return " ";
  endfunction

  // well-formed literal with random content; cut drops the ending character
  task automatic add_literal(bit cut);
    radix_t rx;
    int     ndig;
    bit     in_frac;
    rx      = radix_t'($urandom_range(3));
    in_frac = 1'b0;
    ndig    = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    if (rx == RX_DEC && $urandom_range(4) == 0) begin
      add_char(CH_0, 1'b1);
      add_char(CH_DOT, 1'b0);
      in_frac = 1'b1;
    end else if (rx == RX_DEC) begin
      add_char(8'(CH_1 + $urandom_range(8)), 1'b1);
    end else begin
      add_char(CH_0, 1'b1);
      case (rx)
        RX_BIN:  add_char($urandom_range(1) ? CH_LB : CH_UB, 1'b0);
        RX_OCT:  add_char($urandom_range(1) ? CH_LO : CH_UO, 1'b0);
        default: add_char($urandom_range(1) ? CH_LX : CH_UX, 1'b0);
      endcase
    end
    repeat (ndig) add_char(digit_char(rx), 1'b0);
    if (cut) return;
    if (!in_frac && $urandom_range(2) == 0) begin
      add_char(CH_DOT, 1'b0);
      in_frac = 1'b1;
      ndig = ($urandom_range(9) == 0) ? $urandom_range(14, 30) : $urandom_range(0, 8);
      repeat (ndig) add_char(digit_char(rx), 1'b0);
    end
    add_char(end_char(rx, !in_frac), 1'b0);
  endtask

  task automatic add_noise();
    logic [7:0] c;
    if ($urandom_range(1)) begin
      add_char(8'($urandom_range(255)), 1'($urandom_range(1)));
    end else begin
      // lone zero swallowing a non-prefix character
      add_char(CH_0, 1'b1);
      c = 8'($urandom_range(255));
      while (c == CH_LB || c == CH_UB || c == CH_LO || c == CH_UO || c == CH_LX ||
             c == CH_UX || c == CH_DOT)
        c = 8'($urandom_range(255));
      add_char(c, 1'b0);
    end
  endtask

  initial begin
    int r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed text
    add_char(8'hFF, 1'b0);
    add_char(8'h00, 1'b1);
    add_char(CH_0, 1'b1); add_char("z", 1'b0);
    add_char(CH_0, 1'b1); add_char(CH_LX, 1'b0); add_char(";", 1'b0);
    add_char("7", 1'b1); add_char("3", 1'b1); add_char(CH_DOT, 1'b0);
    add_char("5", 1'b0); add_char(CH_DOT, 1'b0);
    add_char(CH_0, 1'b1); add_char(CH_UO, 1'b0); add_char("7", 1'b0);
    add_char(CH_DOT, 1'b0); add_char("4", 1'b0); add_char(" ", 1'b0);
    add_char(CH_0, 1'b1); add_char(CH_DOT, 1'b0); add_char("5", 1'b0); add_char(8'h80, 1'b0);
    add_char(CH_0, 1'b1); add_char(CH_UB, 1'b0); add_char("1", 1'b0); add_char("2", 1'b0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1:       begin send_idle_pct <= 77; recv_stall_pct <= 0;  end
        2:       begin send_idle_pct <= 0;  recv_stall_pct <= 77; end
        3:       begin send_idle_pct <= 18; recv_stall_pct <= 18; end
        4:       begin send_idle_pct <= 0;  recv_stall_pct <= 0;  hold_req <= 1'b1; end
        default: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
      endcase
      pushed_chars = 0;
      while (pushed_chars < 150) begin
        r = $urandom_range(9);
        if (r < 8) add_literal(1'b0);
        else if (r == 8) add_noise();
        else add_literal(1'b1);
      end
      // wait until every character of this phase is sent and every result is back
      while (text_chars.size() != 0 || in_valid || want_literals.size() != 0)
        @(posedge clk);
    end

    repeat (10) @(posedge clk);
    if (want_literals.size() != 0) flag_mismatch("missing beats", '0, want_literals.size());
    if (errors == 0) begin
      $display("PASS radix_number_literal_scanner");
    end else begin
      $display("FAIL radix_number_literal_scanner");
    end
    $finish;
  end

endmodule

// ===== radix_number_literal_scanner.f =====
rtl/core/rnls_pkg.sv
rtl/core/radix_number_literal_scanner.sv
test/tb.sv
